// ===== src/cscan_pkg.sv =====
// shared constants, types and codes of the c-scan disk scheduler
`default_nettype none

package cscan_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 12;
  localparam int ENTRIES      = MAX_REQUESTS + 3;
  localparam int CNT_BITS     = $clog2(ENTRIES + 1);
  localparam int SUM_BITS     = 18;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [SUM_BITS-1:0]     SUM_LIMIT       = '1;
  localparam logic [TRACK_BITS-1:0]   MAX_TRACK_RESET = TRACK_BITS'(199);
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAD_START  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TRACK   = CFG_IDX_BITS'(1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ADD_HEAD,
    ST_ADD_ZERO,
    ST_ADD_MAX,
    ST_SEEK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_REQ,
    SRC_HEAD,
    SRC_ZERO,
    SRC_MAX
  } src_e;

  typedef struct packed {
    logic insert;
    src_e src;
    logic rotate;
    logic emit_step;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic store_full;
    logic at_head;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/cscan_ctrl.sv =====
// controller state machine: load, add boundary entries, seek head, emit
`default_nettype none

module cscan_ctrl import cscan_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic last_request_i,
  input  wire logic out_stall_i,
  input  sts_t      sts_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_acc  = in_valid_i && (state_q == ST_LOAD);
  assign out_acc = !out_stall_i && (state_q == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && last_request_i) state_d = ST_ADD_HEAD;
      end
      ST_ADD_HEAD: state_d = ST_ADD_ZERO;
      ST_ADD_ZERO: state_d = ST_ADD_MAX;
      ST_ADD_MAX:  state_d = ST_SEEK;
      ST_SEEK: begin
        if (sts_i.at_head) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && sts_i.emit_last) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.src   = SRC_REQ;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o   = 1'b0;
        cmd_o.insert = in_acc && !sts_i.store_full;
      end
      ST_ADD_HEAD: begin
        cmd_o.insert = 1'b1;
        cmd_o.src    = SRC_HEAD;
      end
      ST_ADD_ZERO: begin
        cmd_o.insert = 1'b1;
        cmd_o.src    = SRC_ZERO;
      end
      ST_ADD_MAX: begin
        cmd_o.insert = 1'b1;
        cmd_o.src    = SRC_MAX;
      end
      ST_SEEK: begin
        // entries below the head move to the back of the ring
        cmd_o.rotate = !sts_i.at_head;
      end
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_step = out_acc;
        cmd_o.rotate    = out_acc;
        cmd_o.done      = out_acc && sts_i.emit_last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/cscan_dp.sv =====
// datapath: config registers, sorted track ring, counters and movement sum
`default_nettype none

module cscan_dp import cscan_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [TRACK_BITS-1:0]   cfg_wdata_i,
  input  wire logic [TRACK_BITS-1:0]   request_track_i,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  output logic [TRACK_BITS-1:0]        served_track_o,
  output logic [SUM_BITS-1:0]          total_movement_o
);

  logic [TRACK_BITS-1:0] head_q, max_q;
  logic [TRACK_BITS-1:0] cells_q [ENTRIES];
  logic [TRACK_BITS-1:0] cells_d [ENTRIES];
  logic [ENTRIES-1:0]    gt;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d, cnt_last, pos_q, pos_d;
  logic [TRACK_BITS-1:0] ins_val, prev_q, gap;
  logic [SUM_BITS-1:0]   sum_q, sum_d, sum_next;
  logic [SUM_BITS:0]     sum_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      max_q  <= MAX_TRACK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD_START: head_q <= cfg_wdata_i;
        REG_MAX_TRACK:  max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_REQ:  ins_val = request_track_i;
      SRC_HEAD: ins_val = head_q;
      SRC_ZERO: ins_val = '0;
      SRC_MAX:  ins_val = max_q;
      default:  ins_val = '0;
    endcase
  end

  assign cnt_last = cnt_q - CNT_BITS'(1);

  // each cell either keeps, takes its lower neighbor, takes the new track,
  // or takes its upper neighbor on a rotation
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign gt[g] = (CNT_BITS'(g) >= cnt_q) || (cells_q[g] > ins_val);

    always_comb begin
      cells_d[g] = cells_q[g];
      if (cmd_i.insert && gt[g]) begin
        if (g > 0) begin
          cells_d[g] = gt[(g + ENTRIES - 1) % ENTRIES] ?
                       cells_q[(g + ENTRIES - 1) % ENTRIES] : ins_val;
        end else begin
          cells_d[g] = ins_val;
        end
      end else if (cmd_i.rotate) begin
        cells_d[g] = (CNT_BITS'(g) == cnt_last) ? cells_q[0] : cells_q[(g + 1) % ENTRIES];
      end
    end

    always_ff @(posedge clk_i) begin
      cells_q[g] <= cells_d[g];
    end
  end

  assign gap      = (prev_q > cells_q[0]) ? (prev_q - cells_q[0]) : (cells_q[0] - prev_q);
  assign sum_wide = {1'b0, sum_q} + (SUM_BITS + 1)'(gap);
  assign sum_next = (pos_q == '0) ? '0 :
                    (sum_wide > (SUM_BITS + 1)'(SUM_LIMIT)) ? SUM_LIMIT : sum_wide[SUM_BITS-1:0];

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    sum_d = sum_q;
    if (cmd_i.insert) cnt_d = cnt_q + CNT_BITS'(1);
    if (cmd_i.emit_step) begin
      pos_d = pos_q + CNT_BITS'(1);
      sum_d = sum_next;
    end
    if (cmd_i.done) begin
      cnt_d = '0;
      pos_d = '0;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) prev_q <= cells_q[0];
  end

  assign sts_o.store_full  = (cnt_q >= CNT_BITS'(MAX_REQUESTS));
  assign sts_o.at_head     = (cells_q[0] >= head_q);
  assign sts_o.emit_last   = (pos_q == cnt_last);
  assign served_track_o    = cells_q[0];
  assign total_movement_o  = sts_o.emit_last ? sum_next : '0;

endmodule

`default_nettype wire

// ===== src/cscan_disk_scheduler.sv =====
// c-scan disk scheduler top level: controller plus datapath
// requests load one item per cycle into a sorted register ring (insertion per cycle)
// after the last request the head, 0 and max track are added, then the ring rotates
// until its front is not below the head; then n = stored requests + 3 results follow,
// one per cycle while out_stall_i is low, each read from the front of the ring
// reset (async, low) clears counters, sum and state; head_start 0, max_track 199
`default_nettype none

module cscan_disk_scheduler import cscan_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [TRACK_BITS-1:0]   request_track_i,
  input  wire logic                    last_request_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [TRACK_BITS-1:0]        served_track_o,
  output logic                         end_of_order_o,
  output logic [SUM_BITS-1:0]          total_movement_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [TRACK_BITS-1:0]   cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  cscan_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_request_i (last_request_i),
    .out_stall_i    (out_stall_i),
    .sts_i          (sts),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .cmd_o          (cmd)
  );

  cscan_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .request_track_i  (request_track_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .served_track_o   (served_track_o),
    .total_movement_o (total_movement_o)
  );

  assign end_of_order_o = sts.emit_last;

  // no loading while results are shown
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while results pending");

  // after the final item the block returns to loading
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && end_of_order_o) |=> (!in_stall_o && !out_valid_o))
    else $error("block did not return to loading after final item");

  // movement is reported only on the final item
  a_movement_final_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !end_of_order_o) |-> (total_movement_o == '0))
    else $error("movement shown before final item");

  // insertion never overlaps rotation or emission
  a_insert_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> (!cmd.rotate && !cmd.emit_step))
    else $error("insert overlaps rotation");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for the c-scan disk scheduler: request batches, config phases, order and movement checks
`timescale 1ns / 1ps

module tb_top;
  import cscan_pkg::*;

  typedef struct {
    logic [TRACK_BITS-1:0] track;
    logic                  last;
  } request_t;

  typedef struct {
    logic [TRACK_BITS-1:0] track;
    logic                  order_end;
    logic [SUM_BITS-1:0]   movement;
  } served_t;

  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);
  localparam int TRACK_TOP   = (1 << TRACK_BITS) - 1;
  localparam int DRY_LIMIT   = 4000;
  localparam int RAND_PHASES = 6;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TRACK_BITS-1:0]   req_track = '0;
  logic                    req_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TRACK_BITS-1:0]   srv_track;
  logic                    srv_end;
  logic [SUM_BITS-1:0]     srv_move;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [TRACK_BITS-1:0]   cfg_wdata = '0;

  request_t              pending_q[$];
  served_t               order_q[$];
  logic [TRACK_BITS-1:0] batch_tracks[$];
  logic [TRACK_BITS-1:0] head_cfg = '0;
  logic [TRACK_BITS-1:0] top_cfg = MAX_TRACK_RESET;

  int errors = 0;
  int batches = 0;
  int items_queued = 0;
  int items_in = 0;
  int tracks_out = 0;
  int dry_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit quiet = 1'b0;
  logic in_took = 1'b0;

  cscan_disk_scheduler dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .request_track_i  (req_track),
    .last_request_i   (req_last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .served_track_o   (srv_track),
    .end_of_order_o   (srv_end),
    .total_movement_o (srv_move),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // store one request; on the last one sort the batch and queue its c-scan order
  task automatic take_request(input logic [TRACK_BITS-1:0] track, input logic last);
    logic [TRACK_BITS-1:0] sorted[$];
    logic [TRACK_BITS-1:0] v;
    int j;
    int start;
    int prev;
    int moved;
    served_t r;
    if (batch_tracks.size() < MAX_REQUESTS) batch_tracks.push_back(track);
    if (last) begin
      sorted = batch_tracks;
      sorted.push_back(head_cfg);
      sorted.push_back('0);
      sorted.push_back(top_cfg);
      for (int i = 1; i < sorted.size(); i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      // walk starts at the lowest-index entry equal to the head
      start = 0;
      for (int i = sorted.size() - 1; i >= 0; i--) begin
        if (sorted[i] == head_cfg) start = i;
      end
      moved = 0;
      prev = 0;
      for (int p = 0; p < sorted.size(); p++) begin
        v = sorted[(start + p) % sorted.size()];
        if (p > 0) begin
          moved += (prev > int'(v)) ? prev - int'(v) : int'(v) - prev;
          if (moved > int'(SUM_LIMIT)) moved = int'(SUM_LIMIT);
        end
        prev = int'(v);
        r.track = v;
        r.order_end = (p == sorted.size() - 1);
        r.movement = r.order_end ? SUM_BITS'(moved) : '0;
        order_q.push_back(r);
      end
      batch_tracks.delete();
      batches++;
    end
  endtask

  // monitor: input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk) begin
    served_t want;
    bit moved_any;
    if (rst_n) begin
      moved_any = 1'b0;
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        take_request(req_track, req_last);
        items_in++;
        moved_any = 1'b1;
      end
      if (out_valid && !out_stall) begin
        tracks_out++;
        moved_any = 1'b1;
        if (order_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, track %0d end %0b movement %0d", $time,
                   srv_track, srv_end, srv_move);
        end else begin
          want = order_q.pop_front();
          if (srv_track !== want.track) begin
            errors++;
            $display("%0t: served_track expected %0d actual %0d", $time, want.track, srv_track);
          end
          if (srv_end !== want.order_end) begin
            errors++;
            $display("%0t: end_of_order expected %0b actual %0b", $time, want.order_end, srv_end);
          end
          if (srv_move !== want.movement) begin
            errors++;
            $display("%0t: total_movement expected %0d actual %0d", $time, want.movement,
                     srv_move);
          end
        end
      end
      dry_cycles = moved_any ? 0 : dry_cycles + 1;
      if (dry_cycles >= DRY_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, DRY_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // driver: requests from the pending queue, random idle and stall bursts
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n) begin
      if (!(in_valid && !in_took)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && pending_q.size() > 0 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          req_track <= nxt.track;
          req_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add(input int track, input bit last);
    request_t r;
    r.track = TRACK_BITS'(track);
    r.last = last;
    pending_q.push_back(r);
    items_queued++;
  endtask

  function automatic int pick_track();
    case ($urandom_range(0, 9))
      0: return int'(head_cfg);
      1: return int'(top_cfg);
      2: return $urandom_range(0, 1) ? TRACK_TOP : 0;
      default: return $urandom_range(0, TRACK_TOP);
    endcase
  endfunction

  function automatic int pick_setting();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return TRACK_TOP;
      default: return $urandom_range(0, TRACK_TOP);
    endcase
  endfunction

  task automatic queue_batch(input int len);
    for (int i = 0; i < len; i++) add(pick_track(), i == len - 1);
  endtask

  task automatic drain_and_rest();
    do @(negedge clk); while (items_in != items_queued || order_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= TRACK_BITS'(value);
    if (idx == REG_HEAD_START) head_cfg = TRACK_BITS'(value);
    else if (idx == REG_MAX_TRACK) top_cfg = TRACK_BITS'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_disk(input int head, input int top);
    write_reg(REG_HEAD_START, head);
    write_reg(REG_MAX_TRACK, top);
  endtask

  initial begin
    int phase_items;
    int len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: single top-track request, then duplicates with boundaries
    add(TRACK_TOP, 1'b1);
    add(0, 1'b0);
    add(199, 1'b0);
    add(50, 1'b0);
    add(50, 1'b1);
    drain_and_rest();

    // writes to missing registers must leave the settings alone
    write_reg(REG_SPARE_2, 12'h5A5);
    write_reg(REG_SPARE_3, TRACK_TOP);
    add(7, 1'b1);
    drain_and_rest();

    // requests equal to the head
    set_disk(100, TRACK_TOP);
    add(100, 1'b0);
    add(100, 1'b0);
    add(TRACK_TOP, 1'b0);
    add(0, 1'b0);
    add(2048, 1'b0);
    add(1, 1'b1);
    drain_and_rest();

    // head above the top track
    set_disk(TRACK_TOP, 0);
    add(12'hAAA, 1'b0);
    add(12'h555, 1'b1);
    drain_and_rest();

    set_disk(0, 0);
    add(0, 1'b1);
    drain_and_rest();

    set_disk(TRACK_TOP, TRACK_TOP);
    add(TRACK_TOP, 1'b1);
    drain_and_rest();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      set_disk(pick_setting(), pick_setting());
      phase_items = 0;
      // one phase opens with an overfull batch so the drop path is always hit
      if (p == 2) begin
        queue_batch(MAX_REQUESTS + 4);
        phase_items += MAX_REQUESTS + 4;
      end
      while (phase_items < 15) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 8)
                                           : $urandom_range(1, 8);
        queue_batch(len);
        phase_items += len;
      end
      drain_and_rest();
    end

    repeat (50) @(negedge clk);
    $display("tb_top: %0d batches from %0d requests, %0d tracks served", batches, items_in,
             tracks_out);
    $display("tb_top: reset and extreme settings, ignored writes, full batches, random stalls");
    if (errors == 0 && order_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
